[rtl/ctc_pkg.sv]
// Shared types and constants for the cubic trajectory coefficient pipeline.
// Holds the beat payload structs, the status codes and the inter-stage structs.
// No dependencies.
package ctc_pkg;

  localparam int QUO_W  = 48;
  localparam int MAG_W  = 60;
  localparam int DEN2_W = 48;
  localparam int DEN3_W = 72;

  localparam logic [QUO_W-1:0] POS_LIM = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SAT      = 2'd1,
    STATUS_ZERO_DUR = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] pos_start;
    logic signed [31:0] pos_end;
    logic signed [31:0] vel_start;
    logic signed [31:0] vel_end;
    logic [23:0]        duration;
  } seg_t;

  typedef struct packed {
    logic signed [47:0] coef_zero;
    logic signed [47:0] coef_one;
    logic signed [47:0] coef_two;
    logic signed [47:0] coef_three;
    status_t            status;
  } coef_t;

  typedef struct packed {
    logic              zero;
    logic [31:0]       p0;
    logic [31:0]       v0;
    logic              neg2;
    logic              neg3;
    logic [MAG_W-1:0]  mag2;
    logic [MAG_W-1:0]  mag3;
    logic [DEN2_W-1:0] den2;
    logic [DEN3_W-1:0] den3;
  } front_t;

  typedef struct packed {
    logic              zero;
    logic [31:0]       p0;
    logic [31:0]       v0;
    logic              neg2;
    logic              neg3;
    logic              ovf2;
    logic              ovf3;
    logic [DEN2_W-1:0] den2;
    logic [DEN3_W-1:0] den3;
    logic [DEN2_W-1:0] rem2;
    logic [DEN3_W-1:0] rem3;
    logic [QUO_W-1:0]  low2;
    logic [QUO_W-1:0]  low3;
    logic [QUO_W-1:0]  q2;
    logic [QUO_W-1:0]  q3;
  } div_t;

endpackage

[rtl/cubic_trajectory_coefficients_top.sv]
// Top level of the cubic trajectory coefficient block.
// Instantiates ctc_front, ctc_div and ctc_out; depends on ctc_pkg.
//
// Each segment beat on the seg channel carries start and end position, start
// and end velocity (signed Q16.16) and the duration (unsigned Q8.16). Each
// result beat on the coef channel carries the four Q32.16 coefficients and a
// status code: ok, a coefficient saturated, or zero duration (all zero).
// Both channels use valid and stall; a beat moves when valid is high and stall
// is low.
//
// The pipeline is 55 register stages deep: four front stages for the products
// and numerators, one overflow check stage and 48 divider stages producing one
// quotient bit each, and two output stages. One segment can be taken in every
// cycle while the receiver does not stall a waiting result.
//
// When the receiver stalls a waiting result, the whole pipeline holds and
// seg_stall rises in the same cycle, so nothing is lost or repeated. Reset
// clears all valid bits; no beat is in flight afterwards.
module cubic_trajectory_coefficients_top import ctc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  seg_valid,
  output logic  seg_stall,
  input  seg_t  seg,
  output logic  coef_valid,
  input  logic  coef_stall,
  output coef_t coef
);

  logic   adv;
  logic   fr_valid, dv_valid;
  front_t fr;
  div_t   dv;

  assign adv       = !coef_valid || !coef_stall;
  assign seg_stall = !adv;

  ctc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .seg_valid (seg_valid),
    .seg       (seg),
    .fr_valid  (fr_valid),
    .fr        (fr)
  );

  ctc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .fr_valid (fr_valid),
    .fr       (fr),
    .dv_valid (dv_valid),
    .dv       (dv)
  );

  ctc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .dv_valid   (dv_valid),
    .dv         (dv),
    .coef_valid (coef_valid),
    .coef       (coef)
  );

endmodule

[rtl/ctc_front.sv]
// Front end of the coefficient pipeline: four register stages forming the signed
// numerators and the squared and cubed durations. Depends on ctc_pkg.
module ctc_front import ctc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   seg_valid,
  input  seg_t   seg,
  output logic   fr_valid,
  output front_t fr
);

  logic        v1, v2, v3;
  logic [31:0] p0_1, v0_1, p0_2, v0_2, p0_3, v0_3;
  logic        zero_1, zero_2, zero_3;
  logic [23:0] dur_1;
  logic [32:0] dd_1, dd_2;
  logic [33:0] s2_1;
  logic [32:0] s3_1;
  logic [47:0] dsq_1, den2_2, den2_3;
  logic [MAG_W-1:0] s2x, s3x, durx, ma_2, mb_2, a_3, b_3;
  logic [34:0] dd3_2;
  logic [47:0] pph_2, ppl_2;
  logic [DEN3_W-1:0] den3_3;

  always_comb begin
    s2x  = {{(MAG_W-34){s2_1[33]}}, s2_1};
    s3x  = {{(MAG_W-33){s3_1[32]}}, s3_1};
    durx = {{(MAG_W-24){1'b0}}, dur_1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      fr_valid <= 1'b0;
    end else if (en) begin
      v1       <= seg_valid;
      v2       <= v1;
      v3       <= v2;
      fr_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_1   <= seg.pos_start;
      v0_1   <= seg.vel_start;
      zero_1 <= (seg.duration == 24'd0);
      dur_1  <= seg.duration;
      dd_1   <= {seg.pos_end[31], seg.pos_end} - {seg.pos_start[31], seg.pos_start};
      s2_1   <= {seg.vel_start[31], seg.vel_start, 1'b0}
              + {{2{seg.vel_end[31]}}, seg.vel_end};
      s3_1   <= {seg.vel_start[31], seg.vel_start} + {seg.vel_end[31], seg.vel_end};
      dsq_1  <= {24'd0, seg.duration} * {24'd0, seg.duration};

      p0_2   <= p0_1;
      v0_2   <= v0_1;
      zero_2 <= zero_1;
      ma_2   <= s2x * durx;
      mb_2   <= s3x * durx;
      dd3_2  <= {{2{dd_1[32]}}, dd_1} + {dd_1[32], dd_1, 1'b0};
      dd_2   <= dd_1;
      pph_2  <= {24'd0, dsq_1[47:24]} * {24'd0, dur_1};
      ppl_2  <= {24'd0, dsq_1[23:0]} * {24'd0, dur_1};
      den2_2 <= dsq_1;

      p0_3   <= p0_2;
      v0_3   <= v0_2;
      zero_3 <= zero_2;
      a_3    <= {{(MAG_W-51){dd3_2[34]}}, dd3_2, 16'd0} - ma_2;
      b_3    <= mb_2 - {{(MAG_W-50){dd_2[32]}}, dd_2, 17'd0};
      den3_3 <= {pph_2, 24'd0} + {24'd0, ppl_2};
      den2_3 <= den2_2;

      fr.zero <= zero_3;
      fr.p0   <= p0_3;
      fr.v0   <= v0_3;
      fr.neg2 <= a_3[MAG_W-1];
      fr.neg3 <= b_3[MAG_W-1];
      fr.mag2 <= a_3[MAG_W-1] ? ({MAG_W{1'b0}} - a_3) : a_3;
      fr.mag3 <= b_3[MAG_W-1] ? ({MAG_W{1'b0}} - b_3) : b_3;
      fr.den2 <= den2_3;
      fr.den3 <= den3_3;
    end
  end

endmodule

[rtl/ctc_div.sv]
// Pipelined restoring divider: an overflow check stage, then one quotient bit per
// stage for both coefficient divisions side by side. Depends on ctc_pkg.
module ctc_div import ctc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   fr_valid,
  input  front_t fr,
  output logic   dv_valid,
  output div_t   dv
);

  div_t d      [0:QUO_W];
  div_t d_next [0:QUO_W];
  logic vd     [0:QUO_W];

  function automatic div_t div_init(input front_t f);
    div_t r;
    r.zero = f.zero;
    r.p0   = f.p0;
    r.v0   = f.v0;
    r.neg2 = f.neg2;
    r.neg3 = f.neg3;
    r.den2 = f.den2;
    r.den3 = f.den3;
    r.rem2 = {20'd0, f.mag2[59:32]};
    r.rem3 = {28'd0, f.mag3[59:16]};
    r.ovf2 = (r.rem2 >= f.den2);
    r.ovf3 = (r.rem3 >= f.den3);
    r.low2 = {f.mag2[31:0], 16'd0};
    r.low3 = {f.mag3[15:0], 32'd0};
    r.q2   = '0;
    r.q3   = '0;
    return r;
  endfunction

  function automatic div_t div_step(input div_t s);
    logic [DEN2_W:0] sh2, df2;
    logic [DEN3_W:0] sh3, df3;
    div_t r;
    r    = s;
    sh2  = {s.rem2, s.low2[QUO_W-1]};
    df2  = sh2 - {1'b0, s.den2};
    r.rem2 = df2[DEN2_W] ? sh2[DEN2_W-1:0] : df2[DEN2_W-1:0];
    r.q2   = {s.q2[QUO_W-2:0], ~df2[DEN2_W]};
    r.low2 = {s.low2[QUO_W-2:0], 1'b0};
    sh3  = {s.rem3, s.low3[QUO_W-1]};
    df3  = sh3 - {1'b0, s.den3};
    r.rem3 = df3[DEN3_W] ? sh3[DEN3_W-1:0] : df3[DEN3_W-1:0];
    r.q3   = {s.q3[QUO_W-2:0], ~df3[DEN3_W]};
    r.low3 = {s.low3[QUO_W-2:0], 1'b0};
    return r;
  endfunction

  always_comb begin
    d_next[0] = div_init(fr);
    for (int k = 1; k <= QUO_W; k++) begin
      d_next[k] = div_step(d[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= fr_valid;
      for (int k = 1; k <= QUO_W; k++) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QUO_W; k++) begin
        d[k] <= d_next[k];
      end
    end
  end

  assign dv_valid = vd[QUO_W];
  assign dv       = d[QUO_W];

endmodule

[rtl/ctc_out.sv]
// Output stages: saturation of the quotients, then sign restore and status into
// the output register. Depends on ctc_pkg.
module ctc_out import ctc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  dv_valid,
  input  div_t  dv,
  output logic  coef_valid,
  output coef_t coef
);

  logic             f_valid, f_zero, f_neg2, f_neg3, f_sat;
  logic [31:0]      f_p0, f_v0;
  logic [QUO_W-1:0] f_m2, f_m3, lim2, lim3, m2, m3;
  logic             sat2, sat3;

  always_comb begin
    lim2 = dv.neg2 ? NEG_LIM : POS_LIM;
    lim3 = dv.neg3 ? NEG_LIM : POS_LIM;
    sat2 = dv.ovf2 || (dv.q2 > lim2);
    sat3 = dv.ovf3 || (dv.q3 > lim3);
    m2   = sat2 ? lim2 : dv.q2;
    m3   = sat3 ? lim3 : dv.q3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid    <= 1'b0;
      coef_valid <= 1'b0;
    end else if (en) begin
      f_valid    <= dv_valid;
      coef_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_zero <= dv.zero;
      f_p0   <= dv.p0;
      f_v0   <= dv.v0;
      f_neg2 <= dv.neg2;
      f_neg3 <= dv.neg3;
      f_m2   <= m2;
      f_m3   <= m3;
      f_sat  <= sat2 || sat3;

      coef.coef_zero  <= f_zero ? '0 : {{16{f_p0[31]}}, f_p0};
      coef.coef_one   <= f_zero ? '0 : {{16{f_v0[31]}}, f_v0};
      coef.coef_two   <= f_zero ? '0 : (f_neg2 ? ({QUO_W{1'b0}} - f_m2) : f_m2);
      coef.coef_three <= f_zero ? '0 : (f_neg3 ? ({QUO_W{1'b0}} - f_m3) : f_m3);
      coef.status     <= f_zero ? STATUS_ZERO_DUR : (f_sat ? STATUS_SAT : STATUS_OK);
    end
  end

endmodule
